// ===== sv/mtas_pkg.sv =====
// Shared types and constants for the multi-turn angle to microstep converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mtas_pkg;

    localparam int ANGLE_W    = 14;
    localparam int TURN_W     = 16;
    localparam int UNW_W      = 31;
    localparam int POS_W      = 32;
    localparam int MICRO_W    = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEPS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 8'd1;

    localparam logic [MICRO_W-1:0] MICROSTEPS_RST = 9'd16;

    // Half a sensor turn; the sensor turn is 2**ANGLE_W counts.
    localparam logic signed [ANGLE_W:0] HALF_TURN = 15'sd8192;

    // Added to a negative product before the shift so the quotient truncates toward zero.
    localparam logic [ANGLE_W-1:0] ROUND_BIAS = 14'h3FFF;

    typedef struct packed {
        logic a_ld;
        logic b_ld;
        logic o_ld;
    } t_pipe_ctl;

endpackage

// ===== sv/mtas_unwrap.sv =====
// Turn counter and first pipeline stage: unwraps each angle sample.
// Depends on mtas_pkg.
`timescale 1ns / 1ps

module mtas_unwrap
    import mtas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [ANGLE_W-1:0]       i_angle_sample,
    output logic signed [UNW_W-1:0]  o_unwrapped,
    output logic signed [TURN_W-1:0] o_turns
);

    logic [ANGLE_W-1:0]       r_prev_angle;
    logic [TURN_W-1:0]        r_turns;
    logic [TURN_W-1:0]        n_turns;
    logic signed [ANGLE_W:0]  n_diff;
    logic signed [UNW_W-1:0]  r_a_unw;
    logic signed [UNW_W-1:0]  n_a_unw;
    logic signed [TURN_W-1:0] r_a_turns;

    always_comb begin
        n_diff = $signed({1'b0, i_angle_sample}) - $signed({1'b0, r_prev_angle});
        if (n_diff < -HALF_TURN) begin
            n_turns = r_turns + TURN_W'(1);
        end else if (n_diff > HALF_TURN) begin
            n_turns = r_turns - TURN_W'(1);
        end else begin
            n_turns = r_turns;
        end
        n_a_unw = $signed({n_turns[TURN_W-1], n_turns, i_angle_sample});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_turns      <= '0;
        end else if (i_accept) begin
            r_prev_angle <= i_angle_sample;
            r_turns      <= n_turns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_unw   <= n_a_unw;
            r_a_turns <= $signed(n_turns);
        end
    end

    assign o_unwrapped = r_a_unw;
    assign o_turns     = r_a_turns;

endmodule

// ===== sv/mtas_convert.sv =====
// Scale multiply stage and result register: converts the unwrapped angle to microsteps.
// Depends on mtas_pkg; the stage enables come from the top level.
`timescale 1ns / 1ps

module mtas_convert
    import mtas_pkg::*;
#(
    parameter int SCALE_W = 20
) (
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic signed [UNW_W-1:0]  i_unwrapped,
    input  logic signed [TURN_W-1:0] i_turns,
    input  logic [SCALE_W-1:0]       i_scale,
    input  logic signed [POS_W-1:0]  i_offset,
    output logic signed [POS_W-1:0]  o_motor_position,
    output logic signed [UNW_W-1:0]  o_unwrapped,
    output logic signed [TURN_W-1:0] o_turns
);

    localparam int PROD_W = UNW_W + SCALE_W + 1;

    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [PROD_W-1:0] n_b_prod;
    logic signed [UNW_W-1:0]  r_b_unw;
    logic signed [TURN_W-1:0] r_b_turns;
    logic signed [PROD_W-1:0] n_biased;
    logic signed [POS_W-1:0]  n_pos;
    logic signed [POS_W-1:0]  r_o_pos;
    logic signed [UNW_W-1:0]  r_o_unw;
    logic signed [TURN_W-1:0] r_o_turns;

    always_comb begin
        n_b_prod = PROD_W'(i_unwrapped) * PROD_W'($signed({1'b0, i_scale}));
        n_biased = r_b_prod + (r_b_prod[PROD_W-1] ? $signed(PROD_W'(ROUND_BIAS))
                                                  : $signed(PROD_W'(0)));
        n_pos    = $signed(n_biased[ANGLE_W +: POS_W]) - i_offset;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.b_ld) begin
            r_b_prod  <= n_b_prod;
            r_b_unw   <= i_unwrapped;
            r_b_turns <= i_turns;
        end
        if (i_ctl.o_ld) begin
            r_o_pos   <= n_pos;
            r_o_unw   <= r_b_unw;
            r_o_turns <= r_b_turns;
        end
    end

    assign o_motor_position = r_o_pos;
    assign o_unwrapped      = r_o_unw;
    assign o_turns          = r_o_turns;

endmodule

// ===== sv/multiturn_angle_to_microsteps_core.sv =====
// Top level of the multi-turn angle to microstep converter: handshakes and configuration.
// Depends on mtas_pkg, mtas_unwrap and mtas_convert.
`timescale 1ns / 1ps
//
// Each input word carries one 14-bit absolute angle sample. The block keeps the
// previous sample and a 16-bit turn counter, and returns one output word per
// sample: the motor position in microsteps, the unwrapped angle and the turn count.
// The input and output channels use valid and ready; a word moves on an edge where
// both are high. A separate configuration channel writes the microstep multiplier
// (index 0) and the position offset (index 1); it is always ready, and should be
// used only while no sample is in flight.
// A sample accepted at an edge is registered in the unwrap, scale multiply and offset
// subtract stages in turn before its result is valid. Throughput is one sample per cycle
// while the receiver is ready or a stage is free, set by that three-stage pipeline.
// When the receiver stalls, the stages fill up and the input stays ready until no
// stage is left free. Reset clears the turn counter and the previous angle, sets
// the multiplier to 16 and the offset to 0, and empties the pipeline.
//

module multiturn_angle_to_microsteps_core
    import mtas_pkg::*;
#(
    parameter int MOTOR_STEPS_PER_TURN = 200
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [ANGLE_W-1:0]       i_angle_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_motor_position,
    output logic signed [UNW_W-1:0]  o_unwrapped_angle,
    output logic signed [TURN_W-1:0] o_turn_count,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int STEPS_W = $clog2(MOTOR_STEPS_PER_TURN + 1);
    localparam int SCALE_W = MICRO_W + STEPS_W;
    localparam logic [SCALE_W-1:0] SCALE_RST =
        SCALE_W'(MICROSTEPS_RST * MOTOR_STEPS_PER_TURN);

    t_pipe_ctl                w_ctl;
    logic                     w_in_fire;
    logic                     w_cfg_fire;
    logic                     r_a_valid;
    logic                     r_b_valid;
    logic                     r_o_valid;
    logic [SCALE_W-1:0]       r_scale;
    logic [SCALE_W-1:0]       n_scale;
    logic signed [POS_W-1:0]  r_offset;
    logic signed [UNW_W-1:0]  w_a_unw;
    logic signed [TURN_W-1:0] w_a_turns;

    always_comb begin
        w_ctl.o_ld = !r_o_valid || i_out_ready;
        w_ctl.b_ld = !r_b_valid || w_ctl.o_ld;
        w_ctl.a_ld = !r_a_valid || w_ctl.b_ld;
        w_in_fire  = i_in_valid && w_ctl.a_ld;
        w_cfg_fire = i_cfg_valid;
        n_scale    = SCALE_W'(i_cfg_data[MICRO_W-1:0]) * SCALE_W'(MOTOR_STEPS_PER_TURN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_scale   <= SCALE_RST;
            r_offset  <= '0;
        end else begin
            if (w_ctl.a_ld) begin
                r_a_valid <= w_in_fire;
            end
            if (w_ctl.b_ld) begin
                r_b_valid <= r_a_valid;
            end
            if (w_ctl.o_ld) begin
                r_o_valid <= r_b_valid;
            end
            if (w_cfg_fire && i_cfg_index == CFG_MICROSTEPS) begin
                r_scale <= n_scale;
            end
            if (w_cfg_fire && i_cfg_index == CFG_OFFSET) begin
                r_offset <= $signed(i_cfg_data);
            end
        end
    end

    mtas_unwrap u_unwrap (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_fire),
        .i_angle_sample (i_angle_sample),
        .o_unwrapped    (w_a_unw),
        .o_turns        (w_a_turns)
    );

    mtas_convert #(
        .SCALE_W (SCALE_W)
    ) u_convert (
        .i_clk            (i_clk),
        .i_ctl            (w_ctl),
        .i_unwrapped      (w_a_unw),
        .i_turns          (w_a_turns),
        .i_scale          (r_scale),
        .i_offset         (r_offset),
        .o_motor_position (o_motor_position),
        .o_unwrapped      (o_unwrapped_angle),
        .o_turns          (o_turn_count)
    );

    assign o_in_ready  = w_ctl.a_ld;
    assign o_out_valid = r_o_valid;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for multiturn_angle_to_microsteps_core: predicts unwrapped angle, turn count and
// microstep position for every sample word and checks each output word. Depends on mtas_pkg.

module tb;
    import mtas_pkg::*;

    localparam int STEPS_PER_REV  = 200;
    localparam int COUNTS_PER_REV = 1 << ANGLE_W;
    localparam int HALF_REV       = COUNTS_PER_REV / 2;
    localparam int PIPE_LAT       = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;
    localparam logic [MICRO_W-1:0] MICRO_MAX = 9'h1FF;

    typedef struct packed {
        logic signed [POS_W-1:0]  motor;
        logic signed [UNW_W-1:0]  unwrapped;
        logic signed [TURN_W-1:0] turns;
    } t_position_word;

    class turn_tracker;
        logic [ANGLE_W-1:0]       last_angle;
        logic signed [TURN_W-1:0] turn_cnt;
        logic [MICRO_W-1:0]       usteps;
        logic signed [POS_W-1:0]  offset;
        t_position_word           pending[$];
        int                       errors;

        function new();
            last_angle = '0;
            turn_cnt = '0;
            usteps = MICROSTEPS_RST;
            offset = '0;
            errors = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MICROSTEPS) begin
                usteps = data[MICRO_W-1:0];
            end else if (idx == CFG_OFFSET) begin
                offset = data;
            end
        endfunction

        function void take_sample(logic [ANGLE_W-1:0] angle);
            int diff;
            longint unw;
            longint scaled;
            t_position_word w;
            diff = int'(angle) - int'(last_angle);
            if (diff < -int'(HALF_TURN)) begin
                turn_cnt++;
            end else if (diff > int'(HALF_TURN)) begin
                turn_cnt--;
            end
            last_angle = angle;
            unw = longint'(angle) + longint'(turn_cnt) * COUNTS_PER_REV;
            scaled = unw * longint'(usteps) * STEPS_PER_REV / COUNTS_PER_REV;
            scaled = scaled - longint'(offset);
            w.motor = scaled[POS_W-1:0];
            w.unwrapped = unw[UNW_W-1:0];
            w.turns = turn_cnt;
            pending.push_back(w);
        endfunction

        function void check_word(logic signed [POS_W-1:0] motor,
                                 logic signed [UNW_W-1:0] unwrapped,
                                 logic signed [TURN_W-1:0] turns);
            t_position_word want;
            if (pending.size() == 0) begin
                if (errors < 10) begin
                    $display("Unexpected output word: pos %0d unw %0d turns %0d",
                             motor, unwrapped, turns);
                end
                errors++;
                return;
            end
            want = pending.pop_front();
            if (motor !== want.motor || unwrapped !== want.unwrapped
                    || turns !== want.turns) begin
                if (errors < 10) begin
                    $display("Mismatch at %0t: pos %0d/%0d unw %0d/%0d turns %0d/%0d (exp/act)",
                             $realtime, want.motor, motor, want.unwrapped, unwrapped,
                             want.turns, turns);
                end
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic [ANGLE_W-1:0] in_angle;
    logic rx_ready = 1'b0;
    logic cfg_valid;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic in_ready;
    logic out_valid;
    logic cfg_ready;
    logic signed [POS_W-1:0]  motor_position;
    logic signed [UNW_W-1:0]  unwrapped_angle;
    logic signed [TURN_W-1:0] turn_count;

    turn_tracker tracker = new();
    int burst_left;
    int max_gap;
    int max_stall;
    int rx_hold = 0;

    multiturn_angle_to_microsteps_core #(
        .MOTOR_STEPS_PER_TURN(STEPS_PER_REV)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_angle_sample   (in_angle),
        .o_out_valid      (out_valid),
        .i_out_ready      (rx_ready),
        .o_motor_position (motor_position),
        .o_unwrapped_angle(unwrapped_angle),
        .o_turn_count     (turn_count),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else if (rx_ready && max_stall > 0) begin
            rx_ready = 1'b0;
            rx_hold = $urandom_range(0, max_stall - 1);
        end else begin
            rx_ready = 1'b1;
            rx_hold = $urandom_range(0, 24);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && rx_ready) begin
            tracker.check_word(motor_position, unwrapped_angle, turn_count);
        end
    end

    task automatic send_angle(input logic [ANGLE_W-1:0] angle);
        int gap;
        if (burst_left == 0) begin
            in_valid = 1'b0;
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        in_angle = angle;
        do @(posedge clk); while (!in_ready);
        tracker.take_sample(angle);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 1) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        tracker.apply_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [ANGLE_W-1:0] wander(input logic [ANGLE_W-1:0] from);
        int step;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: step = $urandom_range(0, 600) - 300;
            4, 5, 6: step = $urandom_range(HALF_REV - 4, HALF_REV + 4);
            7: step = $urandom_range(HALF_REV + 5, COUNTS_PER_REV - 1);
            default: return ANGLE_W'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1) begin
            step = -step;
        end
        return ANGLE_W'(int'(from) + step);
    endfunction

    initial begin
        int gaps[4];
        int stalls[4];
        logic [ANGLE_W-1:0] corner_angles[13];

        gaps = '{0, 4, 1, 8};
        stalls = '{0, 6, 2, 8};
        corner_angles = '{14'd16383, 14'd0, 14'd8192, 14'd0, 14'd8193, 14'd0, 14'd1,
                          14'd8194, 14'd2, 14'd16383, 14'd8191, 14'd16383, 14'd8190};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_angle = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        max_gap = 3;
        max_stall = 3;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (corner_angles[i]) begin
            send_angle(corner_angles[i]);
        end
        settle();
        write_reg(CFG_MICROSTEPS, '0);
        write_reg(CFG_OFFSET, 32'h8000_0000);
        send_angle(14'd16383);
        send_angle(14'd5);
        send_angle(14'd9000);
        settle();
        write_reg(CFG_MICROSTEPS, CFG_DATA_W'(MICRO_MAX));
        write_reg(CFG_OFFSET, 32'h7FFF_FFFF);
        send_angle(14'd16383);
        send_angle(14'd0);
        send_angle(14'd16383);
        settle();
        write_reg(CFG_MICROSTEPS, 32'd1);
        write_reg(CFG_OFFSET, 32'd1);
        write_reg(CFG_UNUSED, $urandom);
        send_angle(14'd100);
        send_angle(14'd12000);
        send_angle(14'd3000);
        settle();
        write_reg(CFG_MICROSTEPS, 32'd256);
        send_angle(14'd16000);
        send_angle(14'd200);

        for (int seg = 0; seg < 4; seg++) begin
            settle();
            max_gap = gaps[seg];
            max_stall = stalls[seg];
            write_reg(CFG_MICROSTEPS, $urandom_range(0, MICRO_MAX));
            write_reg(CFG_OFFSET, $urandom);
            for (int i = 0; i < 125; i++) begin
                send_angle(wander(tracker.last_angle));
                if (seg == 2 && i == 60) begin
                    settle();
                end
            end
        end

        in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mtas_pkg.sv
sv/mtas_unwrap.sv
sv/mtas_convert.sv
sv/multiturn_angle_to_microsteps_core.sv
verif/tb.sv
